@@ design/cpfe_pkg.sv @@
// cpfe_pkg: shared types, constants and crc byte-update functions
// for the crc protected frame encoder; no dependencies
package cpfe_pkg;

    // frame length limits and widths
    localparam int MAX_PAYLOAD = 512;
    localparam int LEN_W       = 10;
    localparam int LENF_W      = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_START_BYTE   = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD_LEN  = 2'd1;
    localparam logic [1:0] CFG_COMMAND_CODE = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]       START_BYTE_RST = 8'hA5;
    localparam logic [LEN_W-1:0] PAYLOAD_LEN_RST = LEN_W'(300);
    localparam logic [15:0]      COMMAND_RST     = 16'h0000;

    // crc constants
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [7:0]  CRC8_POLY  = 8'h8C;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'h8408;

    // configuration as seen by the sequencer, length already clamped
    typedef struct packed {
        logic [7:0]       start_byte;
        logic [LEN_W-1:0] frame_len;
        logic [15:0]      command_code;
    } cfg_t;

    // one held input word
    typedef struct packed {
        logic [7:0] seq_num;
        logic [7:0] payload_byte;
    } item_t;

    // reflected crc-8, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // reflected crc-16, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

@@ design/cpfe_cfg.sv @@
// cpfe_cfg: configuration registers and length clamp
// depends on cpfe_pkg
module cpfe_cfg
    import cpfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    logic [7:0]       start_byte_reg;
    logic [LEN_W-1:0] payload_len_reg;
    logic [15:0]      command_code_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= START_BYTE_RST;
            payload_len_reg  <= PAYLOAD_LEN_RST;
            command_code_reg <= COMMAND_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_BYTE:   start_byte_reg   <= cfg_data[7:0];
                CFG_PAYLOAD_LEN:  payload_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_COMMAND_CODE: command_code_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp length to 1..max payload
    always_comb
    begin
        cfg.start_byte   = start_byte_reg;
        cfg.command_code = command_code_reg;
        if (payload_len_reg == '0)
            cfg.frame_len = LEN_W'(1);
        else if (payload_len_reg > LEN_W'(MAX_PAYLOAD))
            cfg.frame_len = LEN_W'(MAX_PAYLOAD);
        else
            cfg.frame_len = payload_len_reg;
    end

endmodule

@@ design/cpfe_in_reg.sv @@
// cpfe_in_reg: single-entry input register holding the current word
// depends on cpfe_pkg
module cpfe_in_reg
    import cpfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] seq_num,
    input  logic [7:0] payload_byte,
    input  logic       consume,
    output logic       item_valid,
    output item_t      item
);

    logic  full_reg;
    item_t item_reg;

    // refill in the same cycle the held word is used up
    assign in_ready   = !full_reg || consume;
    assign item_valid = full_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (in_ready)
            full_reg <= in_valid;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.seq_num      <= seq_num;
            item_reg.payload_byte <= payload_byte;
        end
    end

endmodule

@@ design/cpfe_seq.sv @@
// cpfe_seq: frame sequencer emitting one byte per cycle into the output register
// unless stalled; running crc-8 header check, crc-16 trailer; depends on cpfe_pkg
module cpfe_seq
    import cpfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    input  item_t      item,
    output logic       consume,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       frame_end,
    output logic       run_end
);

    typedef enum logic [3:0] {
        PH_START,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_SEQ,
        PH_HCRC,
        PH_CMD_LO,
        PH_CMD_HI,
        PH_PAY,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc8_reg, crc8_next;
    logic [15:0]      crc16_reg, crc16_next;
    logic             out_valid_reg;
    logic [7:0]       byte_reg;
    logic             fend_reg, rend_reg;

    logic             trailer, out_free, fire, last;
    logic [LEN_W:0]   pos_inc;
    logic [LENF_W-1:0] len16;
    logic [7:0]       byte_sel;
    logic             fend_sel, rend_sel;

    // handshake side
    assign trailer  = (phase_reg == PH_CRC_LO) || (phase_reg == PH_CRC_HI);
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = out_free && (trailer || item_valid);
    assign consume  = fire && (phase_reg == PH_PAY);

    // payload count and end-of-frame test
    assign pos_inc = {1'b0, pos_reg} + (LEN_W+1)'(1);
    assign last    = pos_inc >= {1'b0, cfg.frame_len};
    assign len16   = LENF_W'(cfg.frame_len);

    // byte selection and next phase
    always_comb
    begin
        byte_sel   = 8'h00;
        fend_sel   = 1'b0;
        rend_sel   = 1'b0;
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_START:
            begin
                byte_sel   = cfg.start_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                byte_sel   = len16[7:0];
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                byte_sel   = len16[15:8];
                phase_next = PH_SEQ;
            end
            PH_SEQ:
            begin
                byte_sel   = item.seq_num;
                phase_next = PH_HCRC;
            end
            PH_HCRC:
            begin
                byte_sel   = crc8_reg;
                phase_next = PH_CMD_LO;
            end
            PH_CMD_LO:
            begin
                byte_sel   = cfg.command_code[7:0];
                phase_next = PH_CMD_HI;
            end
            PH_CMD_HI:
            begin
                byte_sel   = cfg.command_code[15:8];
                phase_next = PH_PAY;
            end
            PH_PAY:
            begin
                byte_sel   = item.payload_byte;
                rend_sel   = !last;
                phase_next = last ? PH_CRC_LO : PH_PAY;
            end
            PH_CRC_LO:
            begin
                byte_sel   = crc16_reg[7:0];
                phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                byte_sel   = crc16_reg[15:8];
                fend_sel   = 1'b1;
                rend_sel   = 1'b1;
                phase_next = PH_START;
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    // crc and count updates for the byte going out
    always_comb
    begin
        crc8_next  = crc8_reg;
        crc16_next = crc16_reg;
        pos_next   = pos_reg;
        unique case (phase_reg)
            PH_START:
            begin
                crc8_next  = crc8_byte(CRC8_INIT, byte_sel);
                crc16_next = crc16_byte(CRC16_INIT, byte_sel);
            end
            PH_LEN_LO, PH_LEN_HI, PH_SEQ:
            begin
                crc8_next  = crc8_byte(crc8_reg, byte_sel);
                crc16_next = crc16_byte(crc16_reg, byte_sel);
            end
            PH_HCRC, PH_CMD_LO, PH_CMD_HI:
            begin
                crc16_next = crc16_byte(crc16_reg, byte_sel);
            end
            PH_PAY:
            begin
                crc16_next = crc16_byte(crc16_reg, byte_sel);
                pos_next   = last ? '0 : pos_inc[LEN_W-1:0];
            end
            PH_CRC_LO:
            begin
                crc16_next = crc16_reg;
            end
            PH_CRC_HI:
            begin
                crc16_next = CRC16_INIT;
            end
            default:
            begin
                crc16_next = crc16_reg;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            pos_reg       <= '0;
            crc8_reg      <= CRC8_INIT;
            crc16_reg     <= CRC16_INIT;
            out_valid_reg <= 1'b0;
            byte_reg      <= 8'h00;
            fend_reg      <= 1'b0;
            rend_reg      <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                crc8_reg  <= crc8_next;
                crc16_reg <= crc16_next;
                byte_reg  <= byte_sel;
                fend_reg  <= fend_sel;
                rend_reg  <= rend_sel;
            end
            if (out_free)
                out_valid_reg <= fire;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign frame_end  = fend_reg;
    assign run_end    = rend_reg;

    // frame end is always the last byte of its word
    a_fend_rend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fend_reg |-> rend_reg)
        else $error("frame_end without run_end");

    // payload count stays below the maximum frame length
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < LEN_W'(MAX_PAYLOAD))
        else $error("payload count out of range");

    // mid-header the word that started the frame is still held
    a_hdr_item: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN_LO || phase_reg == PH_LEN_HI || phase_reg == PH_SEQ ||
         phase_reg == PH_HCRC || phase_reg == PH_CMD_LO || phase_reg == PH_CMD_HI)
        |-> item_valid)
        else $error("header in progress without held word");

    // trailer only runs after the count has wrapped
    a_trl_pos: assert property (@(posedge clk) disable iff (!rst_n)
        trailer |-> (pos_reg == '0))
        else $error("trailer with nonzero payload count");

    // a word is used up only when its payload byte goes out
    a_consume: assert property (@(posedge clk) disable iff (!rst_n)
        consume |=> out_valid_reg && (byte_reg == $past(item.payload_byte)))
        else $error("consumed word did not produce its payload byte");

endmodule

@@ design/crc_protected_frame_encoder_core.sv @@
// crc_protected_frame_encoder_core: top level of the framed byte-stream encoder
// a word is held in the input register and its bytes leave through the output register
// throughput: one byte per cycle unless out_ready stalls or a needed word is missing;
// a payload word gives 1 byte, the first word of a frame 8 bytes, the last word 2 more
// reset: config returns to start 0xA5, length 300, command 0; the next word starts a frame
// depends on cpfe_pkg, cpfe_cfg, cpfe_in_reg, cpfe_seq
module crc_protected_frame_encoder_core
    import cpfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  seq_num,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        frame_end,
    output logic        run_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  consume;

    // configuration registers
    cpfe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input word register
    cpfe_in_reg u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .seq_num      (seq_num),
        .payload_byte (payload_byte),
        .consume      (consume),
        .item_valid   (item_valid),
        .item         (item)
    );

    // frame sequencer and output register
    cpfe_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .consume    (consume),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .run_end    (run_end)
    );

endmodule
